// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/rrtr_pkg.sv -----
// Shared types and constants of the round-robin task ring.
`default_nettype none

package rrtr_pkg;

    localparam int ACT_W  = 2;
    localparam int KIND_W = 2;
    localparam int ID_W   = 3;
    localparam int SP_W   = 32;
    localparam int LEN_W  = 16;
    localparam int RUN_W  = 2;

    // actions
    localparam logic [ACT_W-1:0] ACT_CREATE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DELETE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_TICK   = 2'd2;
    localparam logic [ACT_W-1:0] ACT_EXIT   = 2'd3;

    // task kinds for create; any other code makes a normal task
    localparam logic [KIND_W-1:0] KIND_SHELL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_USER  = 2'd2;

    // run states
    localparam logic [RUN_W-1:0] ST_CREATED = 2'd0;
    localparam logic [RUN_W-1:0] ST_READY   = 2'd1;
    localparam logic [RUN_W-1:0] ST_RUNNING = 2'd2;

    // ids that delete refuses
    localparam logic [ID_W-1:0] ID_NULL     = 3'd0;
    localparam logic [ID_W-1:0] ID_RESERVED = 3'd1;

    typedef struct packed {
        logic            ok;
        logic [ID_W-1:0] new_id;
        logic [ID_W-1:0] running_id;
        logic [SP_W-1:0] resume_sp;
        logic            launch_new;
        logic [SP_W-1:0] launch_entry;
    } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rrtr_result_buf.sv -----
// One-entry result register between the sequencer and the result channel.
`default_nettype none

module rrtr_result_buf
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire rrtr_pkg::result_t push_data,
    output logic                  ready,
    output logic                  res_valid,
    input  wire logic             res_stall,
    output rrtr_pkg::result_t     res_data
);

    logic              full_reg;
    logic              full_next;
    rrtr_pkg::result_t data_reg;
    rrtr_pkg::result_t data_next;

    // room when empty or when the held result leaves this cycle
    assign ready = !full_reg || !res_stall;

    always_comb
    begin
        full_next = full_reg;
        data_next = data_reg;
        if (push)
        begin
            full_next = 1'b1;
            data_next = push_data;
        end
        else if (full_reg && !res_stall)
        begin
            full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign res_valid = full_reg;
    assign res_data  = data_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/round_robin_task_ring.sv -----
// Round-robin task ring: task table memories and the command sequencer.
//
// Channel  Dir  Handshake             Payload
// cmd      in   cmd_valid, cmd_stall  action task_kind entry_address stack_base
//                                     stack_length target_id outgoing_sp
// res      out  res_valid, res_stall  ok new_id running_id resume_sp launch_new
//                                     launch_entry
//
// One command at a time. A user-facing create unlinks the shell by a walk to its
// predecessor; delete searches the ring, then walks to the target's predecessor;
// exit may add a walk to the null task. Ring walks step one slot per cycle
// through the link memory's single registered read port.
// Reset is asynchronous with no clearing pass; the null slot's link reads as
// itself until first written. The result register holds one result, so the
// next command is taken while a result waits under res_stall.
`default_nettype none

module round_robin_task_ring
#(
    parameter int SLOTS = 8
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cmd_valid,
    output logic                              cmd_stall,
    input  wire logic [rrtr_pkg::ACT_W-1:0]   action,
    input  wire logic [rrtr_pkg::KIND_W-1:0]  task_kind,
    input  wire logic [rrtr_pkg::SP_W-1:0]    entry_address,
    input  wire logic [rrtr_pkg::SP_W-1:0]    stack_base,
    input  wire logic [rrtr_pkg::LEN_W-1:0]   stack_length,
    input  wire logic [rrtr_pkg::ID_W-1:0]    target_id,
    input  wire logic [rrtr_pkg::SP_W-1:0]    outgoing_sp,
    output logic                              res_valid,
    input  wire logic                         res_stall,
    output logic                              ok,
    output logic [rrtr_pkg::ID_W-1:0]         new_id,
    output logic [rrtr_pkg::ID_W-1:0]         running_id,
    output logic [rrtr_pkg::SP_W-1:0]         resume_sp,
    output logic                              launch_new,
    output logic [rrtr_pkg::SP_W-1:0]         launch_entry
);

    localparam int SW = $clog2(SLOTS);
    localparam int FW = $clog2(SLOTS + 1);
    localparam logic [SW-1:0] CNT_LAST = SW'(SLOTS - 1);
    localparam logic [FW-1:0] FREE_END = FW'(SLOTS);

    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_CR_LINK    = 4'd1;
    localparam logic [3:0] S_CR_HOOK    = 4'd2;
    localparam logic [3:0] S_SEARCH     = 4'd3;
    localparam logic [3:0] S_PREV_ISSUE = 4'd4;
    localparam logic [3:0] S_PREV       = 4'd5;
    localparam logic [3:0] S_NULL_ISSUE = 4'd6;
    localparam logic [3:0] S_NULL       = 4'd7;
    localparam logic [3:0] S_RELINK     = 4'd8;
    localparam logic [3:0] S_TK_STEP    = 4'd9;
    localparam logic [3:0] S_TK_LOAD    = 4'd10;
    localparam logic [3:0] S_DONE       = 4'd11;

    // task table memories
    logic [SW-1:0]                  link_mem  [SLOTS];
    logic [rrtr_pkg::ID_W-1:0]      id_mem    [SLOTS];
    logic [rrtr_pkg::RUN_W-1:0]     run_mem   [SLOTS];
    logic [rrtr_pkg::SP_W-1:0]      sp_mem    [SLOTS];
    logic [rrtr_pkg::SP_W-1:0]      entry_mem [SLOTS];

    logic [SW-1:0]                  rd_addr;
    logic [SW-1:0]                  link_rd_reg;
    logic [rrtr_pkg::ID_W-1:0]      id_rd_reg;
    logic [rrtr_pkg::RUN_W-1:0]     run_rd_reg;
    logic [rrtr_pkg::SP_W-1:0]      sp_rd_reg;
    logic [rrtr_pkg::SP_W-1:0]      entry_rd_reg;
    logic                           link_mask_reg;
    logic                           id_zero_reg;
    logic [SW-1:0]                  link_data;
    logic [rrtr_pkg::ID_W-1:0]      id_data;

    logic                           link_we;
    logic [SW-1:0]                  link_waddr;
    logic [SW-1:0]                  link_wdata;
    logic                           cr_we;
    logic                           sp_we;
    logic [SW-1:0]                  sp_waddr;
    logic [rrtr_pkg::SP_W-1:0]      sp_wdata;
    logic                           run_we;
    logic [SW-1:0]                  run_waddr;
    logic [rrtr_pkg::RUN_W-1:0]     run_wdata;

    // control state
    logic [3:0]                     fsm_reg,        fsm_next;
    logic [SW-1:0]                  cur_reg,        cur_next;
    logic [rrtr_pkg::ID_W-1:0]      cur_id_reg,     cur_id_next;
    logic [FW-1:0]                  free_head_reg,  free_head_next;
    logic [rrtr_pkg::ID_W-1:0]      id_cnt_reg,     id_cnt_next;
    logic [SW-1:0]                  shell_slot_reg, shell_slot_next;
    logic                           shell_valid_reg, shell_valid_next;
    logic [SW-1:0]                  user_slot_reg,  user_slot_next;
    logic                           user_valid_reg, user_valid_next;
    logic                           link0_valid_reg, link0_valid_next;
    logic [SW-1:0]                  walk_s_reg,     walk_s_next;
    logic [SW-1:0]                  walk_cnt_reg,   walk_cnt_next;
    logic [SW-1:0]                  target_reg,     target_next;
    logic [SW-1:0]                  tnext_reg,      tnext_next;
    logic [SW-1:0]                  new_slot_reg,   new_slot_next;
    logic                           relink_reg,     relink_next;

    // command and result payload
    logic [rrtr_pkg::ACT_W-1:0]     act_reg,        act_next;
    logic [rrtr_pkg::KIND_W-1:0]    kind_reg,       kind_next;
    logic [rrtr_pkg::SP_W-1:0]      entry_reg,      entry_next;
    logic [rrtr_pkg::SP_W-1:0]      top_reg,        top_next;
    logic [rrtr_pkg::ID_W-1:0]      tid_reg,        tid_next;
    logic                           ok_reg,         ok_next;
    logic [rrtr_pkg::ID_W-1:0]      new_id_reg,     new_id_next;
    logic [rrtr_pkg::SP_W-1:0]      rsp_reg,        rsp_next;
    logic                           launch_reg,     launch_next;
    logic [rrtr_pkg::SP_W-1:0]      lentry_reg,     lentry_next;

    logic [SW-1:0]                  p_slot;
    logic [SW-1:0]                  tnext_now;
    logic                           prev_hit;
    logic                           push;
    logic                           buf_ready;
    rrtr_pkg::result_t              push_data;
    rrtr_pkg::result_t              res_data;

    assign p_slot    = free_head_reg[SW-1:0];
    assign cmd_stall = (fsm_reg != S_IDLE);

    // the null slot's link reads as zero until written; slot 0's id is never written
    assign link_data = link_mask_reg ? '0 : link_rd_reg;
    assign id_data   = id_zero_reg ? rrtr_pkg::ID_NULL : id_rd_reg;
    assign tnext_now = (walk_cnt_reg == '0) ? link_data : tnext_reg;
    assign prev_hit  = (link_data == target_reg);

    always_comb
    begin
        fsm_next         = fsm_reg;
        cur_next         = cur_reg;
        cur_id_next      = cur_id_reg;
        free_head_next   = free_head_reg;
        id_cnt_next      = id_cnt_reg;
        shell_slot_next  = shell_slot_reg;
        shell_valid_next = shell_valid_reg;
        user_slot_next   = user_slot_reg;
        user_valid_next  = user_valid_reg;
        walk_s_next      = walk_s_reg;
        walk_cnt_next    = walk_cnt_reg;
        target_next      = target_reg;
        tnext_next       = tnext_reg;
        new_slot_next    = new_slot_reg;
        relink_next      = relink_reg;
        act_next         = act_reg;
        kind_next        = kind_reg;
        entry_next       = entry_reg;
        top_next         = top_reg;
        tid_next         = tid_reg;
        ok_next          = ok_reg;
        new_id_next      = new_id_reg;
        rsp_next         = rsp_reg;
        launch_next      = launch_reg;
        lentry_next      = lentry_reg;

        rd_addr    = cur_reg;
        link_we    = 1'b0;
        link_waddr = cur_reg;
        link_wdata = new_slot_reg;
        cr_we      = 1'b0;
        sp_we      = 1'b0;
        sp_waddr   = cur_reg;
        sp_wdata   = outgoing_sp;
        run_we     = 1'b0;
        run_waddr  = cur_reg;
        run_wdata  = rrtr_pkg::ST_READY;
        push       = 1'b0;

        case (fsm_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    act_next      = action;
                    kind_next     = task_kind;
                    entry_next    = entry_address;
                    top_next      = stack_base + rrtr_pkg::SP_W'(stack_length)
                                    - rrtr_pkg::SP_W'(1);
                    tid_next      = target_id;
                    ok_next       = 1'b0;
                    new_id_next   = '0;
                    rsp_next      = '0;
                    launch_next   = 1'b0;
                    lentry_next   = '0;
                    walk_s_next   = cur_reg;
                    walk_cnt_next = '0;
                    case (action)
                        rrtr_pkg::ACT_CREATE:
                        begin
                            fsm_next = (free_head_reg < FREE_END) ? S_CR_LINK : S_DONE;
                        end
                        rrtr_pkg::ACT_DELETE:
                        begin
                            if (target_id == rrtr_pkg::ID_NULL ||
                                target_id == rrtr_pkg::ID_RESERVED)
                            begin
                                fsm_next = S_DONE;
                            end
                            else
                            begin
                                fsm_next = S_SEARCH;
                            end
                        end
                        rrtr_pkg::ACT_TICK:
                        begin
                            // save outgoing sp and mark ready; link read of cur is in flight
                            sp_we    = 1'b1;
                            run_we   = 1'b1;
                            fsm_next = S_TK_STEP;
                        end
                        default:
                        begin
                            if (user_valid_reg)
                            begin
                                ok_next     = 1'b1;
                                target_next = user_slot_reg;
                                relink_next = 1'b0;
                                fsm_next    = S_PREV_ISSUE;
                            end
                            else
                            begin
                                fsm_next = S_DONE;
                            end
                        end
                    endcase
                end
            end

            S_CR_LINK:
            begin
                // new slot takes cur's old successor
                link_we    = 1'b1;
                link_waddr = p_slot;
                link_wdata = link_data;
                cr_we      = 1'b1;
                sp_we      = 1'b1;
                sp_waddr   = p_slot;
                sp_wdata   = top_reg;
                run_we     = 1'b1;
                run_waddr  = p_slot;
                run_wdata  = rrtr_pkg::ST_CREATED;
                new_slot_next  = p_slot;
                new_id_next    = id_cnt_reg;
                ok_next        = 1'b1;
                id_cnt_next    = id_cnt_reg + rrtr_pkg::ID_W'(1);
                free_head_next = free_head_reg + FW'(1);
                if (kind_reg == rrtr_pkg::KIND_SHELL)
                begin
                    shell_slot_next  = p_slot;
                    shell_valid_next = 1'b1;
                end
                if (kind_reg == rrtr_pkg::KIND_USER)
                begin
                    user_slot_next  = p_slot;
                    user_valid_next = 1'b1;
                end
                fsm_next = S_CR_HOOK;
            end

            S_CR_HOOK:
            begin
                link_we    = 1'b1;
                link_waddr = cur_reg;
                link_wdata = new_slot_reg;
                if (kind_reg == rrtr_pkg::KIND_USER && shell_valid_reg)
                begin
                    target_next = shell_slot_reg;
                    relink_next = 1'b0;
                    fsm_next    = S_PREV_ISSUE;
                end
                else
                begin
                    fsm_next = S_DONE;
                end
            end

            S_SEARCH:
            begin
                if (id_data == tid_reg)
                begin
                    ok_next     = 1'b1;
                    target_next = walk_s_reg;
                    relink_next = 1'b0;
                    fsm_next    = S_PREV_ISSUE;
                end
                else if (walk_cnt_reg == CNT_LAST)
                begin
                    fsm_next = S_DONE;
                end
                else
                begin
                    rd_addr       = link_data;
                    walk_s_next   = link_data;
                    walk_cnt_next = walk_cnt_reg + SW'(1);
                end
            end

            S_PREV_ISSUE:
            begin
                rd_addr       = target_reg;
                walk_s_next   = target_reg;
                walk_cnt_next = '0;
                fsm_next      = S_PREV;
            end

            S_PREV:
            begin
                if (walk_cnt_reg == '0)
                begin
                    tnext_next = link_data;
                end
                if (prev_hit || walk_cnt_reg == CNT_LAST)
                begin
                    // relink the predecessor, or the target itself when no predecessor is found
                    link_we    = 1'b1;
                    link_waddr = prev_hit ? walk_s_reg : target_reg;
                    link_wdata = relink_reg ? shell_slot_reg : tnext_now;
                    if (relink_reg)
                    begin
                        fsm_next = S_RELINK;
                    end
                    else if (act_reg == rrtr_pkg::ACT_EXIT && shell_valid_reg)
                    begin
                        fsm_next = S_NULL_ISSUE;
                    end
                    else
                    begin
                        fsm_next = S_DONE;
                    end
                end
                else
                begin
                    rd_addr       = link_data;
                    walk_s_next   = link_data;
                    walk_cnt_next = walk_cnt_reg + SW'(1);
                end
            end

            S_NULL_ISSUE:
            begin
                rd_addr       = cur_reg;
                walk_s_next   = cur_reg;
                walk_cnt_next = '0;
                fsm_next      = S_NULL;
            end

            S_NULL:
            begin
                if (id_data == rrtr_pkg::ID_NULL)
                begin
                    target_next = walk_s_reg;
                    relink_next = 1'b1;
                    fsm_next    = S_PREV_ISSUE;
                end
                else if (walk_cnt_reg == CNT_LAST)
                begin
                    // stop on the slot reached after the last step
                    target_next = link_data;
                    relink_next = 1'b1;
                    fsm_next    = S_PREV_ISSUE;
                end
                else
                begin
                    rd_addr       = link_data;
                    walk_s_next   = link_data;
                    walk_cnt_next = walk_cnt_reg + SW'(1);
                end
            end

            S_RELINK:
            begin
                link_we    = 1'b1;
                link_waddr = shell_slot_reg;
                link_wdata = target_reg;
                fsm_next   = S_DONE;
            end

            S_TK_STEP:
            begin
                cur_next = link_data;
                rd_addr  = link_data;
                fsm_next = S_TK_LOAD;
            end

            S_TK_LOAD:
            begin
                rsp_next = sp_rd_reg;
                if (run_rd_reg != rrtr_pkg::ST_READY)
                begin
                    launch_next = 1'b1;
                    lentry_next = entry_rd_reg;
                end
                run_we      = 1'b1;
                run_waddr   = cur_reg;
                run_wdata   = rrtr_pkg::ST_RUNNING;
                cur_id_next = id_data;
                ok_next     = 1'b1;
                fsm_next    = S_DONE;
            end

            S_DONE:
            begin
                if (buf_ready)
                begin
                    push     = 1'b1;
                    fsm_next = S_IDLE;
                end
            end

            default:
            begin
                fsm_next = S_IDLE;
            end
        endcase
    end

    assign link0_valid_next = link0_valid_reg || (link_we && link_waddr == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg         <= S_IDLE;
            cur_reg         <= '0;
            cur_id_reg      <= rrtr_pkg::ID_NULL;
            free_head_reg   <= FW'(1);
            id_cnt_reg      <= rrtr_pkg::ID_W'(1);
            shell_slot_reg  <= '0;
            shell_valid_reg <= 1'b0;
            user_slot_reg   <= '0;
            user_valid_reg  <= 1'b0;
            link0_valid_reg <= 1'b0;
            link_mask_reg   <= 1'b1;
            id_zero_reg     <= 1'b1;
            walk_s_reg      <= '0;
            walk_cnt_reg    <= '0;
            target_reg      <= '0;
            tnext_reg       <= '0;
            new_slot_reg    <= '0;
            relink_reg      <= 1'b0;
            act_reg         <= rrtr_pkg::ACT_CREATE;
            kind_reg        <= '0;
        end
        else
        begin
            fsm_reg         <= fsm_next;
            cur_reg         <= cur_next;
            cur_id_reg      <= cur_id_next;
            free_head_reg   <= free_head_next;
            id_cnt_reg      <= id_cnt_next;
            shell_slot_reg  <= shell_slot_next;
            shell_valid_reg <= shell_valid_next;
            user_slot_reg   <= user_slot_next;
            user_valid_reg  <= user_valid_next;
            link0_valid_reg <= link0_valid_next;
            // mask decided at read time, so a same-cycle write still reads old
            link_mask_reg   <= (rd_addr == '0) && !link0_valid_reg;
            id_zero_reg     <= (rd_addr == '0);
            walk_s_reg      <= walk_s_next;
            walk_cnt_reg    <= walk_cnt_next;
            target_reg      <= target_next;
            tnext_reg       <= tnext_next;
            new_slot_reg    <= new_slot_next;
            relink_reg      <= relink_next;
            act_reg         <= act_next;
            kind_reg        <= kind_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg  <= entry_next;
        top_reg    <= top_next;
        tid_reg    <= tid_next;
        ok_reg     <= ok_next;
        new_id_reg <= new_id_next;
        rsp_reg    <= rsp_next;
        launch_reg <= launch_next;
        lentry_reg <= lentry_next;
    end

    // memory write ports
    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (cr_we)
        begin
            id_mem[p_slot]    <= id_cnt_reg;
            entry_mem[p_slot] <= entry_reg;
        end
        if (sp_we)
        begin
            sp_mem[sp_waddr] <= sp_wdata;
        end
        if (run_we)
        begin
            run_mem[run_waddr] <= run_wdata;
        end
    end

    // shared registered read port
    always_ff @(posedge clk)
    begin
        link_rd_reg  <= link_mem[rd_addr];
        id_rd_reg    <= id_mem[rd_addr];
        run_rd_reg   <= run_mem[rd_addr];
        sp_rd_reg    <= sp_mem[rd_addr];
        entry_rd_reg <= entry_mem[rd_addr];
    end

    always_comb
    begin
        push_data.ok           = ok_reg;
        push_data.new_id       = new_id_reg;
        push_data.running_id   = cur_id_reg;
        push_data.resume_sp    = rsp_reg;
        push_data.launch_new   = launch_reg;
        push_data.launch_entry = lentry_reg;
    end

    rrtr_result_buf u_result_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .ready     (buf_ready),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    assign ok           = res_data.ok;
    assign new_id       = res_data.new_id;
    assign running_id   = res_data.running_id;
    assign resume_sp    = res_data.resume_sp;
    assign launch_new   = res_data.launch_new;
    assign launch_entry = res_data.launch_entry;

endmodule

`default_nettype wire

// ----- hw/rtl/rrtr_checker.sv -----
// Port-level checker for the round-robin task ring, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module rrtr_checker
(
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         cmd_valid,
    input wire logic                         cmd_stall,
    input wire logic                         res_valid,
    input wire logic                         res_stall,
    input wire logic                         ok,
    input wire logic [rrtr_pkg::ID_W-1:0]    new_id,
    input wire logic [rrtr_pkg::ID_W-1:0]    running_id,
    input wire logic [rrtr_pkg::SP_W-1:0]    resume_sp,
    input wire logic                         launch_new,
    input wire logic [rrtr_pkg::SP_W-1:0]    launch_entry
);

    logic              res_waiting;
    rrtr_pkg::result_t res_bus;
    logic              cmd_transfer;
    logic              refused_clean;

    assign res_waiting   = res_valid && res_stall;
    assign res_bus       = {ok, new_id, running_id, resume_sp, launch_new, launch_entry};
    assign cmd_transfer  = cmd_valid && !cmd_stall;
    assign refused_clean = (new_id == rrtr_pkg::ID_NULL) && !launch_new;

    // a stalled result stays put
    `ASSERT_NEXT(a_res_hold, res_waiting, res_valid && $stable(res_bus), "stalled result changed")
    // one command in work at a time
    `ASSERT_NEXT(a_cmd_busy, cmd_transfer, cmd_stall, "command taken while busy")
    // a launch only comes from a tick, which always succeeds
    `ASSERT_SAME(a_launch_ok, res_valid && launch_new, ok, "launch without ok")
    // refused commands carry no id and no launch
    `ASSERT_SAME(a_refused, res_valid && !ok, refused_clean, "refused result not clean")

endmodule

bind round_robin_task_ring rrtr_checker u_rrtr_checker (.*);

`default_nettype wire

// ----- test/ring_check.sv -----
`timescale 1ns / 100ps
// Task ring checker: watches both channels, predicts each result and compares it.
module ring_check
#(
    parameter int SLOTS = 8
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    input  logic                          cmd_stall,
    input  logic [rrtr_pkg::ACT_W-1:0]    action,
    input  logic [rrtr_pkg::KIND_W-1:0]   task_kind,
    input  logic [rrtr_pkg::SP_W-1:0]     entry_address,
    input  logic [rrtr_pkg::SP_W-1:0]     stack_base,
    input  logic [rrtr_pkg::LEN_W-1:0]    stack_length,
    input  logic [rrtr_pkg::ID_W-1:0]     target_id,
    input  logic [rrtr_pkg::SP_W-1:0]     outgoing_sp,
    input  logic                          res_valid,
    input  logic                          res_stall,
    input  logic                          ok,
    input  logic [rrtr_pkg::ID_W-1:0]     new_id,
    input  logic [rrtr_pkg::ID_W-1:0]     running_id,
    input  logic [rrtr_pkg::SP_W-1:0]     resume_sp,
    input  logic                          launch_new,
    input  logic [rrtr_pkg::SP_W-1:0]     launch_entry,
    output int                            fail_count,
    output int                            pending,
    output int                            checked,
    output int                            launches,
    output int                            refusals
);
    import rrtr_pkg::*;

    localparam int PRINT_CAP = 200;

    // predicted task table
    int                slot_link  [SLOTS];
    logic [ID_W-1:0]   slot_tid   [SLOTS];
    logic [RUN_W-1:0]  slot_run   [SLOTS];
    logic [SP_W-1:0]   slot_sp    [SLOTS];
    logic [SP_W-1:0]   slot_entry [SLOTS];
    int                cur_slot;
    int                free_slot;
    logic [7:0]        id_seq;
    int                shell_at;
    int                user_at;
    bit                has_shell;
    bit                has_user;

    result_t           outcome_q[$];

    int faults     = 0;
    int open_count = 0;
    int n_checked  = 0;
    int n_launch   = 0;
    int n_refused  = 0;

    assign fail_count = faults;
    assign pending    = open_count;
    assign checked    = n_checked;
    assign launches   = n_launch;
    assign refusals   = n_refused;

    task automatic note_fault(input string what, input logic [SP_W-1:0] got,
                              input logic [SP_W-1:0] want);
        faults++;
        // keep the log short when the block is badly off
        if (faults <= PRINT_CAP)
            $display("%0t ns: result %0d, %s is %0h, should be %0h",
                     $time, n_checked, what, got, want);
    endtask

    function automatic int follow(input int s);
        return slot_link[s % SLOTS] % SLOTS;
    endfunction

    // slot whose link points at t; t itself when the ring never returns to it
    function automatic int pred_of(input int t);
        int s;
        s = t;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (follow(s) == t)
                return s;
            s = follow(s);
        end
        return t;
    endfunction

    function automatic int null_slot();
        int s;
        s = cur_slot;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (slot_tid[s] == ID_NULL)
                return s;
            s = follow(s);
        end
        return s;
    endfunction

    task automatic splice_out(input int t);
        slot_link[pred_of(t)] = follow(t);
    endtask

    task automatic clear_table();
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_link[i]  = 0;
            slot_tid[i]   = ID_NULL;
            slot_run[i]   = ST_CREATED;
            slot_sp[i]    = '0;
            slot_entry[i] = '0;
        end
        cur_slot  = 0;
        free_slot = 1;
        id_seq    = 8'd1;
        shell_at  = 0;
        user_at   = 0;
        has_shell = 1'b0;
        has_user  = 1'b0;
    endtask

    task automatic predict_step(output result_t r);
        int p;
        int s;
        int nl;
        r = '0;
        case (action)
            ACT_CREATE:
            begin
                if (free_slot < SLOTS)
                begin
                    p = free_slot;
                    free_slot++;
                    slot_entry[p] = entry_address;
                    slot_run[p]   = ST_CREATED;
                    slot_tid[p]   = id_seq[ID_W-1:0];
                    id_seq        = id_seq + 8'd1;
                    slot_sp[p]    = stack_base + SP_W'(stack_length) - 1;
                    slot_link[p]  = follow(cur_slot);
                    slot_link[cur_slot] = p;
                    if (task_kind == KIND_SHELL)
                    begin
                        shell_at  = p;
                        has_shell = 1'b1;
                    end
                    if (task_kind == KIND_USER)
                    begin
                        user_at  = p;
                        has_user = 1'b1;
                        if (has_shell)
                            splice_out(shell_at);
                    end
                    r.ok     = 1'b1;
                    r.new_id = slot_tid[p];
                end
            end
            ACT_DELETE:
            begin
                if (target_id != ID_NULL && target_id != ID_RESERVED)
                begin
                    s = cur_slot;
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (slot_tid[s] == target_id)
                        begin
                            splice_out(s);
                            r.ok = 1'b1;
                            break;
                        end
                        s = follow(s);
                    end
                end
            end
            ACT_TICK:
            begin
                slot_sp[cur_slot]  = outgoing_sp;
                slot_run[cur_slot] = ST_READY;
                cur_slot    = follow(cur_slot);
                r.resume_sp = slot_sp[cur_slot];
                if (slot_run[cur_slot] != ST_READY)
                begin
                    r.launch_new   = 1'b1;
                    r.launch_entry = slot_entry[cur_slot];
                end
                slot_run[cur_slot] = ST_RUNNING;
                r.ok = 1'b1;
            end
            ACT_EXIT:
            begin
                if (has_user)
                begin
                    splice_out(user_at);
                    // shell goes back in just ahead of the null task
                    if (has_shell)
                    begin
                        nl = null_slot();
                        slot_link[pred_of(nl)] = shell_at;
                        slot_link[shell_at]    = nl;
                    end
                    r.ok = 1'b1;
                end
            end
        endcase
        r.running_id = slot_tid[cur_slot];
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        result_t got;
        if (!rst_n)
        begin
            clear_table();
            outcome_q.delete();
            open_count = 0;
        end
        else
        begin
            // result first: a command taken at this edge cannot have answered yet
            if (res_valid && !res_stall)
            begin
                got.ok           = ok;
                got.new_id       = new_id;
                got.running_id   = running_id;
                got.resume_sp    = resume_sp;
                got.launch_new   = launch_new;
                got.launch_entry = launch_entry;
                if (outcome_q.size() == 0)
                    note_fault("transfer with nothing outstanding", '0, '0);
                else
                begin
                    want = outcome_q.pop_front();
                    if (got.ok != want.ok)
                        note_fault("ok", SP_W'(got.ok), SP_W'(want.ok));
                    if (got.new_id != want.new_id)
                        note_fault("new_id", SP_W'(got.new_id), SP_W'(want.new_id));
                    if (got.running_id != want.running_id)
                        note_fault("running_id", SP_W'(got.running_id),
                                   SP_W'(want.running_id));
                    if (got.resume_sp != want.resume_sp)
                        note_fault("resume_sp", got.resume_sp, want.resume_sp);
                    if (got.launch_new != want.launch_new)
                        note_fault("launch_new", SP_W'(got.launch_new),
                                   SP_W'(want.launch_new));
                    if (got.launch_entry != want.launch_entry)
                        note_fault("launch_entry", got.launch_entry, want.launch_entry);
                    n_checked++;
                end
            end
            if (cmd_valid && !cmd_stall)
            begin
                predict_step(want);
                if (!want.ok)
                    n_refused++;
                if (want.launch_new)
                    n_launch++;
                outcome_q.push_back(want);
            end
            open_count = outcome_q.size();
        end
    end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// Task ring testbench top: clock, reset, command stimulus, result stalls and verdict.
module tb_top;
    import rrtr_pkg::*;

    localparam int SLOTS          = 8;
    localparam int RANDOM_ITEMS   = 1725;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int IDLE_PCT       = 15;

    // create kinds the package leaves unnamed: both make a normal task
    localparam logic [KIND_W-1:0] KIND_PLAIN   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd3;

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               cmd_valid     = 1'b0;
    logic               cmd_stall;
    logic [ACT_W-1:0]   action        = ACT_TICK;
    logic [KIND_W-1:0]  task_kind     = KIND_PLAIN;
    logic [SP_W-1:0]    entry_address = '0;
    logic [SP_W-1:0]    stack_base    = '0;
    logic [LEN_W-1:0]   stack_length  = '0;
    logic [ID_W-1:0]    target_id     = ID_NULL;
    logic [SP_W-1:0]    outgoing_sp   = '0;
    logic               res_valid;
    logic               res_stall     = 1'b0;
    logic               ok;
    logic [ID_W-1:0]    new_id;
    logic [ID_W-1:0]    running_id;
    logic [SP_W-1:0]    resume_sp;
    logic               launch_new;
    logic [SP_W-1:0]    launch_entry;

    int fail_count;
    int pending;
    int checked;
    int launches;
    int refusals;

    bit calm = 1'b0;
    int sent [4] = '{0, 0, 0, 0};

    always #4 clk = ~clk;

    round_robin_task_ring #(.SLOTS(SLOTS)) dut (.*);

    ring_check #(.SLOTS(SLOTS)) u_ring_check (.*);

    always @(negedge clk)
        res_stall = calm ? 1'b0 : ($urandom_range(0, 99) < IDLE_PCT);

    task automatic send_cmd(input logic [ACT_W-1:0] act, input logic [KIND_W-1:0] kind,
                            input logic [SP_W-1:0] entry, input logic [SP_W-1:0] base,
                            input logic [LEN_W-1:0] len, input logic [ID_W-1:0] tid,
                            input logic [SP_W-1:0] osp);
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            cmd_valid = 1'b0;
            @(negedge clk);
        end
        action        = act;
        task_kind     = kind;
        entry_address = entry;
        stack_base    = base;
        stack_length  = len;
        target_id     = tid;
        outgoing_sp   = osp;
        cmd_valid     = 1'b1;
        do
            @(posedge clk);
        while (cmd_stall);
        sent[act]++;
    endtask

    task automatic do_create(input logic [KIND_W-1:0] kind, input logic [SP_W-1:0] entry,
                             input logic [SP_W-1:0] base, input logic [LEN_W-1:0] len);
        send_cmd(ACT_CREATE, kind, entry, base, len, ID_W'($urandom), $urandom);
    endtask

    task automatic do_delete(input logic [ID_W-1:0] tid);
        send_cmd(ACT_DELETE, KIND_W'($urandom), $urandom, $urandom, LEN_W'($urandom), tid,
                 $urandom);
    endtask

    task automatic do_tick(input logic [SP_W-1:0] osp);
        send_cmd(ACT_TICK, KIND_W'($urandom), $urandom, $urandom, LEN_W'($urandom),
                 ID_W'($urandom), osp);
    endtask

    task automatic do_exit();
        send_cmd(ACT_EXIT, KIND_W'($urandom), $urandom, $urandom, LEN_W'($urandom),
                 ID_W'($urandom), $urandom);
    endtask

    task automatic send_random();
        int pick;
        logic [ACT_W-1:0] act;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            act = ACT_TICK;
        else if (pick < 72)
            act = ACT_DELETE;
        else if (pick < 84)
            act = ACT_EXIT;
        else
            act = ACT_CREATE;
        send_cmd(act, KIND_W'($urandom_range(0, 3)), $urandom, $urandom, LEN_W'($urandom),
                 ID_W'($urandom_range(0, 7)), $urandom);
    endtask

    // sender holds off until every outstanding result has been taken
    task automatic drain_hold();
        @(negedge clk);
        cmd_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        do_exit();                                       // no user task yet
        do_tick(32'hFFFF_FFFF);                          // null task alone in the ring
        do_create(KIND_USER, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);  // no shell yet
        do_exit();                                       // exit with no shell
        do_exit();                                       // repeated exit
        do_create(KIND_UNKNOWN, 32'h0, 32'h0, 16'h0);    // stack top wraps
        do_create(KIND_SHELL, 32'h0000_1000, 32'h2000_0000, 16'h0400);
        do_tick(32'h0);
        do_tick(32'h2000_03F0);
        do_create(KIND_USER, 32'h0000_2000, 32'h2000_0400, 16'h0400);  // shell unlinked
        do_delete(ID_NULL);
        do_delete(ID_RESERVED);
        do_delete(3'd7);                                 // id never given
        do_tick($urandom);
        do_delete(3'd4);                                 // the running task
        do_delete(3'd4);                                 // already out of the ring
        do_tick($urandom);                               // follows the stale link
        do_exit();                                       // shell relinked before null
        do_delete(3'd2);
        do_create(KIND_PLAIN, $urandom, $urandom, 16'h0001);
        do_create(KIND_UNKNOWN, $urandom, $urandom, 16'h8000);
        do_create(KIND_SHELL, $urandom, $urandom, 16'h0100);
        do_create(KIND_USER, $urandom, $urandom, 16'h0200);  // pool exhausted
        do_tick($urandom);
        do_tick($urandom);

        drain_hold();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            calm = (n >= 600 && n < 900);
            if (n == 1200)
                drain_hold();
            send_random();
        end

        @(negedge clk);
        cmd_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);

        $display("Ran %0d creates, %0d deletes, %0d ticks and %0d exits through the ring.",
                 sent[ACT_CREATE], sent[ACT_DELETE], sent[ACT_TICK], sent[ACT_EXIT]);
        $display("Compared %0d results: %0d task launches, %0d refused commands.",
                 checked, launches, refusals);
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

endmodule
